### rtl/core/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 8;
  localparam int SLOT_W  = 4;
  localparam int ENTRY_W = 32;

  localparam logic RES_OK   = 1'b0;
  localparam logic RES_FAIL = 1'b1;

  typedef enum logic [1:0] {
    SS_FREE    = 2'd0,
    SS_READY   = 2'd1,
    SS_RUNNING = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_EXIT     = 2'd1,
    OP_SCHEDULE = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CREATE,
    ST_IGNORE,
    ST_EXIT_RD,
    ST_EXIT_CHK,
    ST_SCAN,
    ST_DEMOTE_RD,
    ST_DEMOTE_CHK,
    ST_PROMOTE,
    ST_ENTRY
  } sched_state_e;

endpackage

`default_nettype wire

### rtl/core/round_robin_slot_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin task-slot scheduler. Pulse start while busy is low to issue one command
// (create, exit or schedule); exactly one result beat follows on done_o, held for a single
// cycle, and it cannot be stalled. A sequencer walks the slot-state memory through its one read
// port, one slot per cycle, with a shared wrap-increment and state-compare unit. Create writes
// the state and entry memories together; exit reads the slot state, then checks and frees it;
// schedule scans the state memory, then demotes the running slot, promotes the found slot and
// reads its entry address. The state memory needs no clearing pass: slots are handed out in
// order, so the fresh-slot count marks which entries have ever been written.
module round_robin_slot_scheduler #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  slot_id_i,
  input  wire logic [31:0] entry_address_i,
  output logic             done_o,
  output logic             status_o,
  output logic [3:0]       chosen_slot_o,
  output logic [31:0]      chosen_entry_o
);

  import rrs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [ID_W:0]    SLOTS_ID  = (ID_W + 1)'(SLOTS);

  sched_state_e state_q, state_d;

  logic [ID_W-1:0]    id_q, id_d;
  logic [ENTRY_W-1:0] entry_in_q, entry_in_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;
  logic               cur_valid_q, cur_valid_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0]   issue_cnt_q, issue_cnt_d;
  logic               chk_pend_q, chk_pend_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic [IDX_W-1:0]   found_q, found_d;
  logic               done_q, done_d;
  logic               status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [ENTRY_W-1:0] entry_q, entry_d;

  logic accept;
  logic id_in_range;
  logic scan_found;
  logic scan_none;

  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  slot_state_e        st_wdata;
  logic [IDX_W-1:0]   st_raddr;
  logic [1:0]         st_rdata;
  logic               en_we;
  logic [ENTRY_W-1:0] en_rdata;

  logic [IDX_W-1:0] step_idx;
  logic [IDX_W-1:0] step_chk_idx;
  logic [IDX_W-1:0] step_next;
  logic             step_used;
  logic             step_ready;
  logic             step_running;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign id_in_range = {1'b0, id_q} < SLOTS_ID;
  assign scan_found  = chk_pend_q && step_ready;
  assign scan_none   = !chk_pend_q && (issue_cnt_q == SLOTS_CNT);

  rrs_ram #(
    .WIDTH (2),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (en_we),
    .waddr_i (fresh_q[IDX_W-1:0]),
    .wdata_i (entry_in_q),
    .raddr_i (found_q),
    .rdata_o (en_rdata)
  );

  rrs_step #(
    .SLOTS (SLOTS)
  ) u_step (
    .idx_i     (step_idx),
    .chk_idx_i (step_chk_idx),
    .fresh_i   (fresh_q),
    .status_i  (slot_state_e'(st_rdata)),
    .next_o    (step_next),
    .used_o    (step_used),
    .ready_o   (step_ready),
    .running_o (step_running)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_e'(opcode_i))
            OP_CREATE:   state_d = ST_CREATE;
            OP_EXIT:     state_d = ST_EXIT_RD;
            OP_SCHEDULE: state_d = ST_SCAN;
            default:     state_d = ST_IGNORE;
          endcase
        end
      end
      ST_CREATE:     state_d = ST_IDLE;
      ST_IGNORE:     state_d = ST_IDLE;
      ST_EXIT_RD:    state_d = id_in_range ? ST_EXIT_CHK : ST_IDLE;
      ST_EXIT_CHK:   state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_found) begin
          state_d = ST_DEMOTE_RD;
        end else if (scan_none) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEMOTE_RD:  state_d = cur_valid_q ? ST_DEMOTE_CHK : ST_PROMOTE;
      ST_DEMOTE_CHK: state_d = ST_PROMOTE;
      ST_PROMOTE:    state_d = ST_ENTRY;
      ST_ENTRY:      state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    id_d         = id_q;
    entry_in_d   = entry_in_q;
    fresh_d      = fresh_q;
    cur_valid_d  = cur_valid_q;
    cur_d        = cur_q;
    scan_addr_d  = scan_addr_q;
    issue_cnt_d  = issue_cnt_q;
    chk_pend_d   = chk_pend_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    done_d       = 1'b0;
    status_d     = status_q;
    slot_d       = slot_q;
    entry_d      = entry_q;
    st_we        = 1'b0;
    st_waddr     = found_q;
    st_wdata     = SS_RUNNING;
    st_raddr     = scan_addr_q;
    en_we        = 1'b0;
    step_idx     = scan_addr_q;
    step_chk_idx = chk_idx_q;

    case (state_q)
      ST_IDLE: begin
        step_idx = cur_q;
        if (accept) begin
          id_d        = slot_id_i;
          entry_in_d  = entry_address_i;
          scan_addr_d = cur_valid_q ? step_next : '0;
          issue_cnt_d = '0;
          chk_pend_d  = 1'b0;
        end
      end
      ST_CREATE: begin
        done_d   = 1'b1;
        status_d = RES_FAIL;
        slot_d   = '0;
        entry_d  = '0;
        if (fresh_q < SLOTS_CNT) begin
          st_we    = 1'b1;
          st_waddr = fresh_q[IDX_W-1:0];
          st_wdata = SS_READY;
          en_we    = 1'b1;
          fresh_d  = fresh_q + CNT_W'(1);
          status_d = RES_OK;
          slot_d   = SLOT_W'(fresh_q);
        end
      end
      ST_IGNORE: begin
        done_d   = 1'b1;
        status_d = RES_FAIL;
        slot_d   = '0;
        entry_d  = '0;
      end
      ST_EXIT_RD: begin
        st_raddr = id_q[IDX_W-1:0];
        if (!id_in_range) begin
          done_d   = 1'b1;
          status_d = RES_FAIL;
          slot_d   = '0;
          entry_d  = '0;
        end
      end
      ST_EXIT_CHK: begin
        step_chk_idx = id_q[IDX_W-1:0];
        done_d       = 1'b1;
        status_d     = RES_FAIL;
        slot_d       = '0;
        entry_d      = '0;
        if (step_used) begin
          st_we    = 1'b1;
          st_waddr = id_q[IDX_W-1:0];
          st_wdata = SS_FREE;
          status_d = RES_OK;
        end
      end
      ST_SCAN: begin
        // issue one slot per cycle; check the one issued in the previous cycle
        if (issue_cnt_q != SLOTS_CNT) begin
          scan_addr_d = step_next;
          issue_cnt_d = issue_cnt_q + CNT_W'(1);
          chk_pend_d  = 1'b1;
          chk_idx_d   = scan_addr_q;
        end else begin
          chk_pend_d  = 1'b0;
        end
        if (scan_found) begin
          found_d = chk_idx_q;
        end else if (scan_none) begin
          done_d   = 1'b1;
          status_d = RES_FAIL;
          slot_d   = '0;
          entry_d  = '0;
        end
      end
      ST_DEMOTE_RD: begin
        st_raddr = cur_q;
      end
      ST_DEMOTE_CHK: begin
        step_chk_idx = cur_q;
        if (step_running) begin
          st_we    = 1'b1;
          st_waddr = cur_q;
          st_wdata = SS_READY;
        end
      end
      ST_PROMOTE: begin
        st_we       = 1'b1;
        st_waddr    = found_q;
        st_wdata    = SS_RUNNING;
        cur_valid_d = 1'b1;
        cur_d       = found_q;
      end
      ST_ENTRY: begin
        done_d   = 1'b1;
        status_d = RES_OK;
        slot_d   = SLOT_W'(found_q);
        entry_d  = en_rdata;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fresh_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      chk_pend_q  <= 1'b0;
      issue_cnt_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= fresh_d;
      cur_valid_q <= cur_valid_d;
      cur_q       <= cur_d;
      chk_pend_q  <= chk_pend_d;
      issue_cnt_q <= issue_cnt_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    entry_in_q  <= entry_in_d;
    scan_addr_q <= scan_addr_d;
    chk_idx_q   <= chk_idx_d;
    found_q     <= found_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    entry_q     <= entry_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign chosen_slot_o  = slot_q;
  assign chosen_entry_o = entry_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result beat while sequencer busy");

  a_fail_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == RES_FAIL) |-> (chosen_slot_o == '0 && chosen_entry_o == '0))
    else $error("failed beat carries non-zero payload");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (fresh_q <= SLOTS_CNT))
    else $error("fresh slot count past table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_cur_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |=> cur_valid_q)
    else $error("current task flag dropped");

endmodule

`default_nettype wire

### rtl/core/rrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/rrs_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rrs_step #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  wire logic [IDX_W-1:0]   idx_i,
  input  wire logic [IDX_W-1:0]   chk_idx_i,
  input  wire logic [CNT_W-1:0]   fresh_i,
  input  rrs_pkg::slot_state_e    status_i,
  output logic      [IDX_W-1:0]   next_o,
  output logic                    used_o,
  output logic                    ready_o,
  output logic                    running_o
);

  import rrs_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  logic handed_out;

  // slots at or beyond the fresh count were never created and read as free
  assign handed_out = CNT_W'(chk_idx_i) < fresh_i;

  assign next_o    = (idx_i == LAST) ? '0 : idx_i + IDX_W'(1);
  assign used_o    = handed_out && (status_i != SS_FREE);
  assign ready_o   = handed_out && (status_i == SS_READY);
  assign running_o = handed_out && (status_i == SS_RUNNING);

endmodule

`default_nettype wire
